### rtl/aff_pkg.sv
`default_nettype none

package aff_pkg;

	localparam int SYMBOL_BITS = 8;
	localparam int WIDE_BITS   = 2 * SYMBOL_BITS;
	localparam int SIGN_BITS   = SYMBOL_BITS + 2;
	localparam int CNT_BITS    = $clog2(WIDE_BITS + 1);
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	typedef logic [SYMBOL_BITS-1:0] sym_t;

	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOINV = 2'd2;

	localparam logic [1:0] REG_MODULUS  = 2'd0;
	localparam logic [1:0] REG_KEY_MULT = 2'd1;
	localparam logic [1:0] REG_KEY_ADD  = 2'd2;

	localparam sym_t MODULUS_RST  = sym_t'(26);
	localparam sym_t KEY_MULT_RST = sym_t'(1);
	localparam sym_t KEY_ADD_RST  = sym_t'(0);

	typedef struct packed {
		logic opcode;
		sym_t symbol_in;
	} in_t;

	typedef struct packed {
		sym_t       symbol_out;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		sym_t modulus;
		sym_t key_mult;
		sym_t key_add;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic                 half;
		logic [WIDE_BITS-1:0] dividend;
		sym_t                 divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [WIDE_BITS-1:0] quot;
		sym_t                 rem;
	} div_rsp_t;

endpackage

`default_nettype wire

### rtl/aff_cfg.sv
`default_nettype none

module aff_cfg import aff_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic      [DATA_BITS-1:0] prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	sym_t       modulus_q;
	sym_t       key_mult_q;
	sym_t       key_add_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RST;
			key_mult_q <= KEY_MULT_RST;
			key_add_q  <= KEY_ADD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODULUS:  modulus_q  <= pwdata[SYMBOL_BITS-1:0];
				REG_KEY_MULT: key_mult_q <= pwdata[SYMBOL_BITS-1:0];
				REG_KEY_ADD:  key_add_q  <= pwdata[SYMBOL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MODULUS:  prdata[SYMBOL_BITS-1:0] = modulus_q;
			REG_KEY_MULT: prdata[SYMBOL_BITS-1:0] = key_mult_q;
			REG_KEY_ADD:  prdata[SYMBOL_BITS-1:0] = key_add_q;
			default:      prdata = '0;
		endcase
	end

	assign cfg.modulus  = modulus_q;
	assign cfg.key_mult = key_mult_q;
	assign cfg.key_add  = key_add_q;

endmodule

`default_nettype wire

### rtl/aff_div.sv
`default_nettype none

module aff_div import aff_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WIDE_BITS-1:0] dvd_q;
	logic [WIDE_BITS-1:0] quo_q;
	sym_t                 rem_q;
	sym_t                 dvs_q;
	logic [SYMBOL_BITS:0] trial;
	logic [SYMBOL_BITS:0] diff;
	logic                 ge;

	// Restoring division: one quotient bit per cycle. The partial remainder
	// stays below the divisor, so one compare and subtract suffices.
	assign trial = {rem_q, dvd_q[WIDE_BITS-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.half ? CNT_BITS'(SYMBOL_BITS) : CNT_BITS'(WIDE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// A short operand is moved to the top so that only its bits are walked.
			dvd_q <= req.half ? {req.dividend[SYMBOL_BITS-1:0], {SYMBOL_BITS{1'b0}}}
			                  : req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WIDE_BITS-2:0], 1'b0};
			quo_q <= {quo_q[WIDE_BITS-2:0], ge};
			rem_q <= ge ? diff[SYMBOL_BITS-1:0] : trial[SYMBOL_BITS-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && $past(busy_q)) |-> rem_q < dvs_q)
		else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

### rtl/aff_core.sv
`default_nettype none

module aff_core import aff_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_t      in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_t          out_data,
	output div_req_t      div_req,
	input  wire div_rsp_t div_rsp
);

	localparam int PROD_BITS = 2 * SYMBOL_BITS + 3;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_RED_A    = 10'b0000000010,
		S_RED_B    = 10'b0000000100,
		S_EU_CHK   = 10'b0000001000,
		S_EU_DIV   = 10'b0000010000,
		S_EU_UPD   = 10'b0000100000,
		S_MUL      = 10'b0001000000,
		S_FIN_WAIT = 10'b0010000000,
		S_OUT      = 10'b0100000000,
		S_SPARE    = 10'b1000000000
	} state_t;

	state_t                       state_q;
	logic                         start_q;
	logic                         half_q;
	logic [WIDE_BITS-1:0]         dvd_q;
	sym_t                         dvs_q;
	logic                         op_q;
	sym_t                         x_q;
	sym_t                         a_q;
	sym_t                         b_q;
	sym_t                         r1_q;
	sym_t                         r2_q;
	logic signed [SIGN_BITS-1:0]  s1_q;
	logic signed [SIGN_BITS-1:0]  s2_q;
	logic signed [PROD_BITS-1:0]  qs_q;
	sym_t                         mul_a_q;
	sym_t                         mul_b_q;
	sym_t                         add_q;
	sym_t                         res_q;
	logic [1:0]                   status_q;

	logic                         range_err;
	logic signed [PROD_BITS-1:0]  qs_w;
	logic signed [PROD_BITS-1:0]  s_new_w;
	logic signed [SIGN_BITS-1:0]  m_s;
	logic signed [SIGN_BITS-1:0]  inv_s;
	logic [SYMBOL_BITS:0]         d_sum;
	logic [SYMBOL_BITS:0]         d_fix;
	logic [WIDE_BITS-1:0]         prod_w;

	assign range_err = in_data.symbol_in >= cfg.modulus;

	assign qs_w    = $signed({1'b0, div_rsp.quot[SYMBOL_BITS-1:0]}) * s2_q;
	assign s_new_w = $signed({{(PROD_BITS-SIGN_BITS){s1_q[SIGN_BITS-1]}}, s1_q}) - qs_q;

	// Bezout coefficient folded into the least non-negative residue.
	assign m_s = $signed({2'b00, cfg.modulus});
	always_comb begin
		if (s1_q < 0) begin
			inv_s = s1_q + m_s;
		end else if (s1_q >= m_s) begin
			inv_s = s1_q - m_s;
		end else begin
			inv_s = s1_q;
		end
	end

	// Both x and b lie below m, so x + m - b is in (0, 2m).
	assign d_sum = {1'b0, x_q} + {1'b0, cfg.modulus} - {1'b0, b_q};
	assign d_fix = (d_sum >= {1'b0, cfg.modulus}) ? d_sum - {1'b0, cfg.modulus} : d_sum;

	assign prod_w = {{SYMBOL_BITS{1'b0}}, mul_a_q} * {{SYMBOL_BITS{1'b0}}, mul_b_q}
	              + {{SYMBOL_BITS{1'b0}}, add_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (range_err) begin
							state_q <= S_OUT;
						end else begin
							start_q <= 1'b1;
							state_q <= S_RED_A;
						end
					end
				end
				S_RED_A: begin
					if (div_rsp.done) begin
						start_q <= 1'b1;
						state_q <= S_RED_B;
					end
				end
				S_RED_B: begin
					if (div_rsp.done) begin
						state_q <= (op_q == OP_ENC) ? S_MUL : S_EU_CHK;
					end
				end
				S_EU_CHK: begin
					if (r2_q == '0) begin
						state_q <= (r1_q == sym_t'(1)) ? S_MUL : S_OUT;
					end else begin
						start_q <= 1'b1;
						state_q <= S_EU_DIV;
					end
				end
				S_EU_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_EU_UPD;
					end
				end
				S_EU_UPD: state_q <= S_EU_CHK;
				S_MUL: begin
					start_q <= 1'b1;
					state_q <= S_FIN_WAIT;
				end
				S_FIN_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q     <= in_data.opcode;
					x_q      <= in_data.symbol_in;
					dvd_q    <= {{SYMBOL_BITS{1'b0}}, cfg.key_mult};
					dvs_q    <= cfg.modulus;
					half_q   <= 1'b1;
					res_q    <= '0;
					status_q <= range_err ? ST_RANGE : ST_OK;
				end
			end
			S_RED_A: begin
				if (div_rsp.done) begin
					a_q   <= div_rsp.rem;
					dvd_q <= {{SYMBOL_BITS{1'b0}}, cfg.key_add};
				end
			end
			S_RED_B: begin
				if (div_rsp.done) begin
					b_q     <= div_rsp.rem;
					mul_a_q <= a_q;
					mul_b_q <= x_q;
					add_q   <= div_rsp.rem;
					r1_q    <= a_q;
					r2_q    <= cfg.modulus;
					s1_q    <= SIGN_BITS'(1);
					s2_q    <= '0;
				end
			end
			S_EU_CHK: begin
				if (r2_q == '0) begin
					if (r1_q == sym_t'(1)) begin
						mul_a_q <= inv_s[SYMBOL_BITS-1:0];
						mul_b_q <= d_fix[SYMBOL_BITS-1:0];
						add_q   <= '0;
					end else begin
						status_q <= ST_NOINV;
					end
				end else begin
					dvd_q  <= {{SYMBOL_BITS{1'b0}}, r1_q};
					dvs_q  <= r2_q;
					half_q <= 1'b1;
				end
			end
			S_EU_DIV: begin
				if (div_rsp.done) begin
					r1_q <= r2_q;
					r2_q <= div_rsp.rem;
					qs_q <= qs_w;
				end
			end
			S_EU_UPD: begin
				s1_q <= s2_q;
				s2_q <= s_new_w[SIGN_BITS-1:0];
			end
			S_MUL: begin
				dvd_q  <= prod_w;
				dvs_q  <= cfg.modulus;
				half_q <= 1'b0;
			end
			S_FIN_WAIT: begin
				if (div_rsp.done) begin
					res_q <= div_rsp.rem;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign out_data.symbol_out = res_q;
	assign out_data.status     = status_q;

	assign div_req.start    = start_q;
	assign div_req.half     = half_q;
	assign div_req.dividend = dvd_q;
	assign div_req.divisor  = dvs_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> out_data.symbol_out == '0)
		else $error("flagged result carries a nonzero symbol");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

endmodule

`default_nettype wire

### rtl/affine_cipher_symbol.sv
// Affine cipher on one symbol: encrypt (a*x+b) mod m, decrypt inv(a)*(y-b) mod m.
// Sequence: key_mult and key_add are reduced mod m, then the product is reduced mod m;
// decrypt runs extended Euclid steps in between, each a divider pass and a coefficient update.
// Throughput: one item at a time; every division, and the mod-m reduction of the keys and of the
// final product, goes through one shared restoring divider that yields one quotient bit per cycle.
// Reset: arst_n clears the sequencer and loads modulus 26, key_mult 1, key_add 0.
`default_nettype none

module affine_cipher_symbol import aff_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic      [DATA_BITS-1:0] prdata,
	output logic                      pready,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_t                  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_t                      out_data
);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	aff_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aff_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	aff_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

endmodule

`default_nettype wire
